[rtl/ctcgd_pkg.sv]
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types, widths and codes of the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam int SCORE_W    = 16;
  localparam int LABEL_W    = 13;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 9;
  localparam int TOTAL_W    = 25;
  localparam int WINNER_W   = 14;
  localparam int DIVIDEND_W = TOTAL_W + 1;
  localparam int ITER_W     = $clog2(DIVIDEND_W + 1);

  localparam int DEF_MAX_CLASSES = 8192;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [WINNER_W-1:0] WINNER_NONE = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;

  localparam logic signed [TOTAL_W:0] TOTAL_MAX = 26'sd16777215;
  localparam logic signed [TOTAL_W:0] TOTAL_MIN = -26'sd16777216;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPACE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  // Register indexes.
  localparam logic REG_LABEL_COUNT = 1'b0;

  // One finished row as handed from the front to the back.
  typedef struct packed {
    logic                      emit;
    logic                      seq_end;
    logic [KIND_W-1:0]         kind;
    logic [LABEL_W-1:0]        label_index;
    logic signed [SCORE_W-1:0] token_score;
  } rec_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COUNT_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/ctc_greedy_decoder_core.sv]
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core
// CTC greedy best-path decoder over a stream of Q4.12 class scores.
// Takes one score beat per cycle while in_ready is high; a token passes from
// the beat that ends its row through the row queue and the output registers.
// A summary waits on the bit-serial mean divider (one quotient bit a cycle).
// Queue depth rows may finish meanwhile before in_ready drops.
// Synchronous active-low reset clears the row state, the totals and label_count.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_core #(
  parameter int MAX_CLASSES = ctcgd_pkg::DEF_MAX_CLASSES,
  parameter int QUEUE_DEPTH = ctcgd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ctcgd_pkg::SCORE_W-1:0] in_class_score,
  input  logic                                 in_row_end,
  input  logic                                 in_sequence_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ctcgd_pkg::KIND_W-1:0]         out_kind,
  output logic [ctcgd_pkg::LABEL_W-1:0]        out_label_index,
  output logic signed [ctcgd_pkg::SCORE_W-1:0] out_token_score,
  output logic signed [ctcgd_pkg::SCORE_W-1:0] out_mean_confidence,
  output logic [ctcgd_pkg::COUNT_W-1:0]        out_emitted_count,
  output logic                                 out_last
);
  import ctcgd_pkg::*;

  logic [LABEL_W-1:0] label_count_r;
  logic               cfg_write;
  logic               q_ready;
  logic               q_push;
  rec_t               q_rec;
  logic               rd_valid;
  rec_t               rd_rec;
  logic               pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_LABEL_COUNT) ? 32'(label_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_count_r <= '0;
    end else if (cfg_write && (paddr[2] == REG_LABEL_COUNT)) begin
      label_count_r <= pwdata[LABEL_W-1:0];
    end
  end

  ctcgd_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_class_score  (in_class_score),
    .in_row_end      (in_row_end),
    .in_sequence_end (in_sequence_end),
    .label_count     (label_count_r),
    .q_ready         (q_ready),
    .q_push          (q_push),
    .q_rec           (q_rec)
  );

  ctcgd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_rec   (q_rec),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_rec   (rd_rec)
  );

  ctcgd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rd_valid            (rd_valid),
    .rd_rec              (rd_rec),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_label_index     (out_label_index),
    .out_token_score     (out_token_score),
    .out_mean_confidence (out_mean_confidence),
    .out_emitted_count   (out_emitted_count),
    .out_last            (out_last)
  );

endmodule

[rtl/ctcgd_front.sv]
// ----------------------------------------------------------------------------
// ctcgd_front
// Running arg-max over the scores of a row, and token classification at the
// end of each row against the previous winner and the label count.
// ----------------------------------------------------------------------------
module ctcgd_front #(
  parameter int MAX_CLASSES = ctcgd_pkg::DEF_MAX_CLASSES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ctcgd_pkg::SCORE_W-1:0] in_class_score,
  input  logic                               in_row_end,
  input  logic                               in_sequence_end,
  input  logic [ctcgd_pkg::LABEL_W-1:0]      label_count,
  input  logic                               q_ready,
  output logic                               q_push,
  output ctcgd_pkg::rec_t                    q_rec
);
  import ctcgd_pkg::*;

  localparam int CLS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int WW    = ((CLS_W > WINNER_W) ? CLS_W : WINNER_W) + 1;
  localparam logic [CLS_W-1:0] POS_LAST = CLS_W'(MAX_CLASSES - 1);

  logic signed [SCORE_W-1:0] best_value_r, best_value_nxt;
  logic [CLS_W-1:0]          best_class_r, best_class_nxt;
  logic [CLS_W-1:0]          class_pos_r, class_pos_nxt;
  logic [WINNER_W-1:0]       prev_winner_r, prev_winner_nxt;

  logic                      fire;
  logic                      take;
  logic signed [SCORE_W-1:0] cur_value;
  logic [CLS_W-1:0]          cur_class;
  logic [WW-1:0]             win_w;
  logic [WW-1:0]             prev_w;
  logic [WW-1:0]             lc_w;
  logic                      fresh;
  logic                      is_char;
  logic                      is_space;

  assign in_ready = q_ready;
  assign fire     = in_valid && in_ready;

  // The first score of a row always wins; later ones must be strictly greater.
  assign take      = (class_pos_r == '0) || (in_class_score > best_value_r);
  assign cur_value = take ? in_class_score : best_value_r;
  assign cur_class = take ? class_pos_r : best_class_r;

  assign win_w    = WW'(cur_class);
  assign prev_w   = WW'(prev_winner_r);
  assign lc_w     = WW'(label_count);
  assign fresh    = (win_w != '0) && (win_w != prev_w);
  assign is_char  = fresh && (win_w <= lc_w);
  assign is_space = fresh && (win_w == lc_w + WW'(1));

  always_comb begin
    best_value_nxt  = best_value_r;
    best_class_nxt  = best_class_r;
    class_pos_nxt   = class_pos_r;
    prev_winner_nxt = prev_winner_r;
    q_push          = 1'b0;
    q_rec.emit        = is_char || is_space;
    q_rec.seq_end     = in_sequence_end;
    q_rec.kind        = is_char ? KIND_CHAR : KIND_SPACE;
    q_rec.label_index = is_char ? LABEL_W'(win_w - WW'(1)) : '0;
    q_rec.token_score = cur_value;
    if (fire) begin
      if (in_row_end) begin
        best_value_nxt  = '0;
        best_class_nxt  = '0;
        class_pos_nxt   = '0;
        prev_winner_nxt = in_sequence_end ? WINNER_NONE : WINNER_W'(cur_class);
        q_push          = is_char || is_space || in_sequence_end;
      end else begin
        best_value_nxt = cur_value;
        best_class_nxt = cur_class;
        if (class_pos_r < POS_LAST) begin
          class_pos_nxt = class_pos_r + CLS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_value_r  <= '0;
      best_class_r  <= '0;
      class_pos_r   <= '0;
      prev_winner_r <= WINNER_NONE;
    end else begin
      best_value_r  <= best_value_nxt;
      best_class_r  <= best_class_nxt;
      class_pos_r   <= class_pos_nxt;
      prev_winner_r <= prev_winner_nxt;
    end
  end

endmodule

[rtl/ctcgd_fifo.sv]
// ----------------------------------------------------------------------------
// ctcgd_fifo
// Small register queue of finished rows between the front and the back.
// ----------------------------------------------------------------------------
module ctcgd_fifo #(
  parameter int DEPTH = ctcgd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ctcgd_pkg::rec_t wr_rec,
  output logic            wr_ready,
  input  logic            pop,
  output logic            rd_valid,
  output ctcgd_pkg::rec_t rd_rec
);
  import ctcgd_pkg::*;

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

[rtl/ctcgd_div.sv]
// ----------------------------------------------------------------------------
// ctcgd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctcgd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ctcgd_pkg::div_req_t req,
  output ctcgd_pkg::div_rsp_t rsp
);
  import ctcgd_pkg::*;

  logic [DIVIDEND_W-1:0] quo_r;
  logic [COUNT_W-1:0]    rem_r;
  logic [COUNT_W-1:0]    divisor_r;
  logic [ITER_W-1:0]     iter_r;
  logic                  busy_r;
  logic                  done_r;
  logic [COUNT_W:0]      trial;
  logic                  fits;

  // The remainder stays below the divisor, so the shifted trial fits one more bit.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, divisor_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(DIVIDEND_W);
      end else if (busy_r) begin
        iter_r <= iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? COUNT_W'(trial - {1'b0, divisor_r}) : COUNT_W'(trial);
    end
  end

endmodule

[rtl/ctcgd_back.sv]
// ----------------------------------------------------------------------------
// ctcgd_back
// Emits tokens, keeps the saturating score sum and token count, and builds
// the end-of-sequence summary with the rounded mean score.
// ----------------------------------------------------------------------------
module ctcgd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_valid,
  input  ctcgd_pkg::rec_t                      rd_rec,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ctcgd_pkg::KIND_W-1:0]         out_kind,
  output logic [ctcgd_pkg::LABEL_W-1:0]        out_label_index,
  output logic signed [ctcgd_pkg::SCORE_W-1:0] out_token_score,
  output logic signed [ctcgd_pkg::SCORE_W-1:0] out_mean_confidence,
  output logic [ctcgd_pkg::COUNT_W-1:0]        out_emitted_count,
  output logic                                 out_last
);
  import ctcgd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_SUM   = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]         kind_r;
  logic [LABEL_W-1:0]        label_r;
  logic signed [SCORE_W-1:0] token_r;
  logic signed [SCORE_W-1:0] mean_r;
  logic [COUNT_W-1:0]        emitted_r;
  logic                      last_r;

  logic                      out_free;
  logic                      load_token;
  logic                      load_sum;
  logic signed [TOTAL_W:0]   tot_ext;
  logic signed [TOTAL_W:0]   sum;
  logic [DIVIDEND_W-1:0]     magnitude;
  logic [SCORE_W-1:0]        mean_val;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  ctcgd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign tot_ext  = {total_r[TOTAL_W-1], total_r};
  assign sum      = tot_ext + (TOTAL_W+1)'(rd_rec.token_score);

  // Rounding to nearest, halves away from zero: divide |total| + count/2.
  assign magnitude = tot_ext[TOTAL_W] ? DIVIDEND_W'(-tot_ext) : DIVIDEND_W'(tot_ext);
  assign div_req.start    = (state_r == ST_START);
  assign div_req.dividend = magnitude + DIVIDEND_W'(count_r >> 1);
  assign div_req.divisor  = count_r;

  always_comb begin
    if (count_r == '0) begin
      mean_val = '0;
    end else if (total_r[TOTAL_W-1]) begin
      mean_val = SCORE_W'(~div_rsp.quotient + DIVIDEND_W'(1));
    end else begin
      mean_val = SCORE_W'(div_rsp.quotient);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    count_nxt  = count_r;
    pop        = 1'b0;
    load_token = 1'b0;
    load_sum   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (rd_valid) begin
          if (rd_rec.emit) begin
            if (out_free) begin
              load_token = 1'b1;
              pop        = 1'b1;
              if (sum > TOTAL_MAX) begin
                total_nxt = TOTAL_MAX[TOTAL_W-1:0];
              end else if (sum < TOTAL_MIN) begin
                total_nxt = TOTAL_MIN[TOTAL_W-1:0];
              end else begin
                total_nxt = sum[TOTAL_W-1:0];
              end
              if (count_r != COUNT_MAX) begin
                count_nxt = count_r + COUNT_W'(1);
              end
              if (rd_rec.seq_end) begin
                state_nxt = ST_START;
              end
            end
          end else begin
            pop = 1'b1;
            if (rd_rec.seq_end) begin
              state_nxt = ST_START;
            end
          end
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          load_sum  = 1'b1;
          total_nxt = '0;
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_token || load_sum) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_token) begin
      kind_r    <= rd_rec.kind;
      label_r   <= rd_rec.label_index;
      token_r   <= rd_rec.token_score;
      mean_r    <= '0;
      emitted_r <= '0;
      last_r    <= !rd_rec.seq_end;
    end else if (load_sum) begin
      kind_r    <= KIND_SUMMARY;
      label_r   <= '0;
      token_r   <= '0;
      mean_r    <= mean_val;
      emitted_r <= count_r;
      last_r    <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_label_index     = label_r;
  assign out_token_score     = token_r;
  assign out_mean_confidence = mean_r;
  assign out_emitted_count   = emitted_r;
  assign out_last            = last_r;

endmodule
